>>> src/lirs_pkg.sv
// shared types and constants for the linear interpolation resampler
package lirs_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int LEN_W      = 16;
    localparam int FRAC_W     = 16;
    localparam int STEP_W     = 21;
    localparam int RATIO_W    = 20;
    localparam int TOTAL_W    = 20;
    localparam int PHASE_W    = 33;
    localparam int POS_W      = PHASE_W - FRAC_W;
    localparam int PROD_W     = LEN_W + RATIO_W;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int MUL_W      = DIFF_W + FRAC_W + 1;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;
    localparam int PCM_W      = 16;
    localparam int MAG_W      = 21;
    localparam int SCALE_W    = 15;

    localparam logic [CNT_W-1:0]    MAX_RESULTS = CNT_W'(20);
    localparam logic [SCALE_W-1:0]  PCM_SCALE   = SCALE_W'(32767);
    localparam logic signed [SAMPLE_W-1:0] ONE_Q20     = SAMPLE_W'(1048576);
    localparam logic signed [SAMPLE_W-1:0] MINUS_ONE_Q20 = -SAMPLE_W'(1048576);

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OUT_RATIO  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PCM16_MODE = CFG_IDX_W'(2);

    localparam logic [STEP_W-1:0]  PHASE_STEP_RESET = STEP_W'(65536);
    localparam logic [RATIO_W-1:0] OUT_RATIO_RESET  = RATIO_W'(65536);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_TOTAL,
        ST_CHECK,
        ST_MUL,
        ST_VAL,
        ST_PCM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic calc_prod;
        logic calc_total;
        logic issue;
        logic mul;
        logic interp;
        logic pcm;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic frame_start;
        logic more;
    } status_t;

endpackage

>>> src/lirs_if.sv
// channel interfaces: input samples, results and register writes
interface lirs_sample_if;
    import lirs_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [LEN_W-1:0]           frame_length;
    modport source (output valid, output sample, output frame_length, input ready);
    modport sink (input valid, input sample, input frame_length, output ready);
endinterface

interface lirs_result_if;
    import lirs_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic                       run_last;
    modport source (output valid, output out_sample, output run_last, input ready);
    modport sink (input valid, input out_sample, input run_last, output ready);
endinterface

interface lirs_cfg_if;
    import lirs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/linear_interp_resampler_pcm16_top.sv
// top level of the linear interpolation resampler with pcm16 output stage
// Mono Q3.20 samples arrive one per transfer on feed, each carrying its buffer length, which is
// latched from the first sample of a buffer. A buffer gives round(length*out_ratio) results, each
// interpolated at position i*phase_step and sent as soon as the sample right of it has arrived,
// at most 20 per sample; run_last marks the last result caused by a sample. One sample is handled
// at a time: on the first sample of a buffer the length times ratio product is formed first, and
// each result passes through the difference multiplier, the interpolation add and the pcm scaling
// multiplier before it is offered on result. Register writes on cfg are always accepted and are
// meant for when no sample is in flight.
module linear_interp_resampler_pcm16_top (
    input logic       clk,
    input logic       rst_n,
    lirs_sample_if.sink   feed,
    lirs_result_if.source result,
    lirs_cfg_if.sink      cfg
);
    import lirs_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg.ready = 1'b1;

    lirs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .feed_valid   (feed.valid),
        .feed_ready   (feed.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    lirs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .sample       (feed.sample),
        .frame_length (feed.frame_length),
        .out_sample   (result.out_sample),
        .run_last     (result.run_last)
    );

endmodule

>>> src/lirs_ctrl.sv
// controller state machine sequencing one item and its results
module lirs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              feed_valid,
    output logic              feed_ready,
    output logic              result_valid,
    input  logic              result_ready,
    input  lirs_pkg::status_t status,
    output lirs_pkg::cmd_t    cmd
);
    import lirs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (feed_valid)
                begin
                    state_next = status.frame_start ? ST_LEN : ST_CHECK;
                end
            end
            ST_LEN:   state_next = ST_TOTAL;
            ST_TOTAL: state_next = ST_CHECK;
            ST_CHECK: state_next = status.more ? ST_MUL : ST_IDLE;
            ST_MUL:   state_next = ST_VAL;
            ST_VAL:   state_next = ST_PCM;
            ST_PCM:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (result_ready)
                begin
                    state_next = ST_CHECK;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        feed_ready   = 1'b0;
        result_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                feed_ready    = 1'b1;
                cmd.load_item = feed_valid;
            end
            ST_LEN:   cmd.calc_prod = 1'b1;
            ST_TOTAL: cmd.calc_total = 1'b1;
            ST_CHECK:
            begin
                cmd.issue  = status.more;
                cmd.finish = !status.more;
            end
            ST_MUL:   cmd.mul = 1'b1;
            ST_VAL:   cmd.interp = 1'b1;
            ST_PCM:   cmd.pcm = 1'b1;
            ST_OUT:   result_valid = 1'b1;
            default:  cmd = '0;
        endcase
    end

endmodule

>>> src/lirs_datapath.sv
// datapath: registers, position tracking, interpolation and pcm scaling
module lirs_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lirs_pkg::cmd_t                       cmd,
    output lirs_pkg::status_t                    status,
    input  logic                                 cfg_we,
    input  logic [lirs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lirs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] sample,
    input  logic [lirs_pkg::LEN_W-1:0]           frame_length,
    output logic signed [lirs_pkg::SAMPLE_W-1:0] out_sample,
    output logic                                 run_last
);
    import lirs_pkg::*;

    logic [STEP_W-1:0]          phase_step_reg;
    logic [RATIO_W-1:0]         out_ratio_reg;
    logic                       pcm_mode_reg;
    logic signed [SAMPLE_W-1:0] prev_reg;
    logic signed [SAMPLE_W-1:0] cur_reg;
    logic [LEN_W-1:0]           in_idx_reg;
    logic [TOTAL_W-1:0]         out_idx_reg;
    logic [PHASE_W-1:0]         phase_reg;
    logic [LEN_W-1:0]           len_reg;
    logic [TOTAL_W-1:0]         total_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic                       use_cur_reg;
    logic signed [MUL_W-1:0]    mul_reg;
    logic signed [SAMPLE_W-1:0] val_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       run_last_reg;

    logic [POS_W-1:0]           pos;
    logic                       last_item;
    logic                       more;
    logic [PHASE_W:0]           phase_sum;
    logic [PHASE_W-1:0]         phase_next;
    logic [LEN_W-1:0]           len_in;
    logic [PROD_W:0]            prod_rnd;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [MUL_W-1:0]    mul_rnd;
    logic signed [MUL_W-FRAC_W-1:0] interp_sum;
    logic signed [SAMPLE_W-1:0] val_next;
    logic signed [SAMPLE_W-1:0] clamped;
    logic                       neg;
    logic [MAG_W-1:0]           mag;
    logic [MAG_W+SCALE_W-1:0]   scaled;
    logic [SAMPLE_W-1:0]        pcm_mag;
    logic signed [SAMPLE_W-1:0] pcm_val;

    assign pos       = phase_reg[PHASE_W-1:FRAC_W];
    assign last_item = ({1'b0, in_idx_reg} + (LEN_W+1)'(1)) >= {1'b0, len_reg};
    assign more      = (count_reg < MAX_RESULTS) && (out_idx_reg < total_reg)
                       && (last_item
                           || ({1'b0, pos} < {{(POS_W+1-LEN_W){1'b0}}, in_idx_reg}));

    assign status.more        = more;
    assign status.frame_start = (in_idx_reg == '0);

    assign phase_sum  = {1'b0, phase_reg} + {{(PHASE_W+1-STEP_W){1'b0}}, phase_step_reg};
    assign phase_next = phase_sum[PHASE_W] ? {PHASE_W{1'b1}} : phase_sum[PHASE_W-1:0];

    assign len_in   = (frame_length == '0) ? LEN_W'(1) : frame_length;
    assign prod_rnd = {1'b0, prod_reg} + (PROD_W+1)'(1 << (FRAC_W - 1));

    assign diff       = DIFF_W'(cur_reg) - DIFF_W'(prev_reg);
    assign mul_rnd    = mul_reg + MUL_W'(1 << (FRAC_W - 1));
    assign interp_sum = (MUL_W-FRAC_W)'(prev_reg) + mul_rnd[MUL_W-1:FRAC_W];
    assign val_next   = use_cur_reg ? cur_reg : interp_sum[SAMPLE_W-1:0];

    always_comb
    begin
        clamped = val_reg;
        if (val_reg > ONE_Q20)
        begin
            clamped = ONE_Q20;
        end
        else if (val_reg < MINUS_ONE_Q20)
        begin
            clamped = MINUS_ONE_Q20;
        end
    end

    assign neg     = clamped[SAMPLE_W-1];
    assign mag     = neg ? MAG_W'(-clamped) : MAG_W'(clamped);
    assign scaled  = mag * PCM_SCALE;
    assign pcm_mag = {{(SAMPLE_W-PCM_W){1'b0}}, scaled[MAG_W+SCALE_W-1:20]};
    assign pcm_val = neg ? -$signed(pcm_mag) : $signed(pcm_mag);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RESET;
            out_ratio_reg  <= OUT_RATIO_RESET;
            pcm_mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PHASE_STEP: phase_step_reg <= cfg_data[STEP_W-1:0];
                REG_OUT_RATIO:  out_ratio_reg <= cfg_data[RATIO_W-1:0];
                REG_PCM16_MODE: pcm_mode_reg <= cfg_data[0];
                default:        pcm_mode_reg <= pcm_mode_reg;
            endcase
        end
    end

    // stream position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            in_idx_reg  <= '0;
            out_idx_reg <= '0;
            phase_reg   <= '0;
            len_reg     <= '0;
            total_reg   <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                count_reg <= '0;
                if (in_idx_reg == '0)
                begin
                    len_reg <= len_in;
                end
            end
            if (cmd.calc_total)
            begin
                total_reg   <= prod_rnd[FRAC_W +: TOTAL_W];
                out_idx_reg <= '0;
                phase_reg   <= '0;
            end
            if (cmd.issue)
            begin
                out_idx_reg <= out_idx_reg + TOTAL_W'(1);
                count_reg   <= count_reg + CNT_W'(1);
                phase_reg   <= phase_next;
            end
            if (cmd.finish)
            begin
                prev_reg <= cur_reg;
                if (last_item)
                begin
                    in_idx_reg  <= '0;
                    out_idx_reg <= '0;
                    phase_reg   <= '0;
                end
                else
                begin
                    in_idx_reg <= in_idx_reg + LEN_W'(1);
                end
            end
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            cur_reg <= sample;
        end
        if (cmd.calc_prod)
        begin
            prod_reg <= len_reg * out_ratio_reg;
        end
        if (cmd.issue)
        begin
            frac_reg    <= phase_reg[FRAC_W-1:0];
            use_cur_reg <= ({1'b0, pos} + (POS_W+1)'(1))
                           >= {{(POS_W+1-LEN_W){1'b0}}, len_reg};
        end
        if (cmd.mul)
        begin
            mul_reg <= diff * $signed({1'b0, frac_reg});
        end
        if (cmd.interp)
        begin
            val_reg <= val_next;
        end
        if (cmd.pcm)
        begin
            out_sample_reg <= pcm_mode_reg ? pcm_val : val_reg;
            run_last_reg   <= !more;
        end
    end

    assign out_sample = out_sample_reg;
    assign run_last   = run_last_reg;

endmodule

>>> bench/linear_interp_resampler_pcm16_top_tb.sv
// self-checking testbench for the linear interpolation resampler with pcm16 output stage
module linear_interp_resampler_pcm16_top_tb;
    import lirs_pkg::*;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = 20;
    localparam int     REPORT_LIMIT   = 10;
    localparam longint POS_MAX        = (longint'(1) << PHASE_W) - 1;
    localparam longint UNITY          = longint'(1) << FRAC_W;
    localparam longint HALF_LSB       = longint'(1) << (FRAC_W - 1);
    localparam longint BIAS           = longint'(1) << (SAMPLE_W - 1);
    localparam longint LEN_MASK       = (longint'(1) << LEN_W) - 1;
    localparam longint TOTAL_MASK     = (longint'(1) << TOTAL_W) - 1;

    typedef struct {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       run_last;
    } result_t;

    class resampler_board;
        logic [STEP_W-1:0]  phase_inc;
        logic [RATIO_W-1:0] rate_ratio;
        logic               pcm_on;
        longint             prev_value;
        longint             in_pos;
        longint             out_count;
        longint             position;
        longint             frame_len;
        longint             frame_total;
        result_t            expected_q[$];
        int                 errors;
        int                 samples_seen;
        int                 results_seen;
        int                 writes_seen;

        function new();
            phase_inc    = PHASE_STEP_RESET;
            rate_ratio   = OUT_RATIO_RESET;
            pcm_on       = 1'b0;
            prev_value   = 0;
            in_pos       = 0;
            out_count    = 0;
            position     = 0;
            frame_len    = 0;
            frame_total  = 0;
            errors       = 0;
            samples_seen = 0;
            results_seen = 0;
            writes_seen  = 0;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            writes_seen++;
            case (idx)
                REG_PHASE_STEP: phase_inc  = data[STEP_W-1:0];
                REG_OUT_RATIO:  rate_ratio = data[RATIO_W-1:0];
                REG_PCM16_MODE: pcm_on     = data[0];
                default: ;
            endcase
        endfunction

        // predicts every result that one accepted sample releases
        function void take_sample(logic signed [SAMPLE_W-1:0] smp, logic [LEN_W-1:0] flen);
            longint  cur;
            longint  pos;
            longint  fr;
            longint  v;
            longint  mag;
            int      count;
            bit      at_end;
            result_t r;
            cur = longint'(smp);
            samples_seen++;
            if (in_pos == 0)
            begin
                frame_len   = (flen == 0) ? 1 : longint'(flen);
                frame_total = ((frame_len * longint'(rate_ratio) + HALF_LSB) >> FRAC_W)
                              & TOTAL_MASK;
                out_count   = 0;
                position    = 0;
            end
            at_end = (in_pos + 1 >= frame_len);
            count  = 0;
            while (count < int'(MAX_RESULTS) && out_count < frame_total)
            begin
                pos = position >> FRAC_W;
                fr  = position & (UNITY - 1);
                if (!at_end && pos + 1 > in_pos)
                    break;
                // past the last input the last sample repeats
                if (pos + 1 >= frame_len)
                    v = cur;
                else
                    v = (((prev_value + BIAS) * (UNITY - fr) + (cur + BIAS) * fr + HALF_LSB)
                         >> FRAC_W) - BIAS;
                if (pcm_on)
                begin
                    if (v > longint'(ONE_Q20))
                        v = longint'(ONE_Q20);
                    if (v < longint'(MINUS_ONE_Q20))
                        v = longint'(MINUS_ONE_Q20);
                    mag = (v < 0) ? -v : v;
                    mag = (mag * longint'(PCM_SCALE)) >> 20;
                    v   = (v < 0) ? -mag : mag;
                end
                r.out_sample = v[SAMPLE_W-1:0];
                r.run_last   = 1'b0;
                expected_q.push_back(r);
                count++;
                out_count = (out_count + 1) & TOTAL_MASK;
                position  = position + longint'(phase_inc);
                if (position > POS_MAX)
                    position = POS_MAX;
            end
            if (count > 0)
                expected_q[expected_q.size()-1].run_last = 1'b1;
            prev_value = cur;
            if (at_end)
            begin
                in_pos    = 0;
                out_count = 0;
                position  = 0;
            end
            else
                in_pos = (in_pos + 1) & LEN_MASK;
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] smp, logic last);
            result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result: sample %0d run_last %0b", smp, last);
                return;
            end
            want = expected_q.pop_front();
            if (smp !== want.out_sample || last !== want.run_last)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("result %0d mismatch: expected sample %0d run_last %0b, got %0d %0b",
                             results_seen, want.out_sample, want.run_last, smp, last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   feed_gaps;
    bit   result_stalls;

    resampler_board board = new();

    lirs_sample_if feed_ch();
    lirs_result_if res_ch();
    lirs_cfg_if    cfg_ch();

    linear_interp_resampler_pcm16_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (feed_ch.valid && feed_ch.ready)
                board.take_sample(feed_ch.sample, feed_ch.frame_length);
            if (cfg_ch.valid && cfg_ch.ready)
                board.set_reg(cfg_ch.index, cfg_ch.data);
            if (res_ch.valid && res_ch.ready)
                board.check_result(res_ch.out_sample, res_ch.run_last);
        end
    end

    // result side backpressure
    initial
    begin
        res_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (result_stalls && $urandom_range(0, 4) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((feed_ch.valid && feed_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("linear_interp_resampler_pcm16_top_tb NOT OK");
        $finish;
    end

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        if ($urandom_range(0, 2) == 0)
            return SAMPLE_W'($urandom);
        return SAMPLE_W'($urandom_range(0, 2621440) - 1310720);
    endfunction

    function automatic int rand_len();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return $urandom_range(1, 6);
        if (pick < 19)
            return $urandom_range(7, 16);
        return $urandom_range(17, 40);
    endfunction

    function automatic logic [STEP_W-1:0] matched_step(logic [RATIO_W-1:0] r);
        return STEP_W'(((longint'(1) << 32) + longint'(r) / 2) / longint'(r));
    endfunction

    // valid stays high from one item to the next unless a gap is inserted
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp,
                               input logic [LEN_W-1:0] flen);
        if (feed_gaps && $urandom_range(0, 4) == 0)
        begin
            feed_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        feed_ch.valid        <= 1'b1;
        feed_ch.sample       <= smp;
        feed_ch.frame_length <= flen;
        @(posedge clk);
        while (!feed_ch.ready) @(posedge clk);
    endtask

    // length field only matters on the first item of a buffer
    task automatic send_frame(input int n);
        send_sample(rand_sample(), LEN_W'(n));
        for (int i = 1; i < n; i++)
            send_sample(rand_sample(), LEN_W'($urandom));
    endtask

    task automatic settle();
        feed_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [STEP_W-1:0] s, input logic [RATIO_W-1:0] r,
                                 input logic p);
        settle();
        write_reg(REG_PHASE_STEP, CFG_DATA_W'(s));
        write_reg(REG_OUT_RATIO, CFG_DATA_W'(r));
        write_reg(REG_PCM16_MODE, CFG_DATA_W'(p));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_phase(input int n, input logic [STEP_W-1:0] s,
                                input logic [RATIO_W-1:0] r, input logic p);
        int sent;
        int len;
        apply_setting(s, r, p);
        sent = 0;
        while (sent < n)
        begin
            len = rand_len();
            send_frame(len);
            sent += len;
        end
    endtask

    initial
    begin
        logic [RATIO_W-1:0] r;
        rst_n                <= 1'b0;
        feed_ch.valid        <= 1'b0;
        feed_ch.sample       <= '0;
        feed_ch.frame_length <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= REG_PHASE_STEP;
        cfg_ch.data          <= '0;
        feed_gaps     = 1'b1;
        result_stalls = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: zero length counts as one, full scale swings
        send_sample(SAMPLE_W'(8388607), LEN_W'(0));
        send_sample(SAMPLE_W'(-8388608), LEN_W'(3));
        send_sample(SAMPLE_W'(8388607), LEN_W'(65535));
        send_sample(SAMPLE_W'(0), LEN_W'(0));

        // 2x upsampling into pcm16: clamping and truncation toward zero
        apply_setting(STEP_W'(32768), RATIO_W'(131072), 1'b1);
        send_sample(SAMPLE_W'(1048577), LEN_W'(4));
        send_sample(SAMPLE_W'(-1048577), LEN_W'(4));
        send_sample(SAMPLE_W'(1048576), LEN_W'(4));
        send_sample(SAMPLE_W'(-1), LEN_W'(4));
        send_sample(SAMPLE_W'(-1048576), LEN_W'(2));
        send_sample(SAMPLE_W'(8388607), LEN_W'(2));

        // widest step with most results: backlog flushed on the last item, excess dropped
        apply_setting(STEP_W'(2097151), RATIO_W'(524288), 1'b0);
        send_frame(4);

        // narrowest step: per-item cap holds results back
        apply_setting(STEP_W'(2048), RATIO_W'(524288), 1'b1);
        send_frame(3);

        // smallest ratio: a buffer with no results at all
        apply_setting(STEP_W'(65536), RATIO_W'(2048), 1'b0);
        send_frame(3);

        r = RATIO_W'($urandom_range(65536, 262144));
        random_phase(30, matched_step(r), r, 1'b1);
        r = RATIO_W'($urandom_range(16384, 65536));
        random_phase(30, matched_step(r), r, 1'b0);
        random_phase(30, STEP_W'($urandom_range(2048, 2097151)),
                     RATIO_W'($urandom_range(2048, 524288)), 1'($urandom));

        // closing stretch at full rate, ending inside a maximum length buffer
        feed_gaps     = 1'b0;
        result_stalls = 1'b0;
        r = RATIO_W'($urandom_range(40000, 140000));
        random_phase(24, matched_step(r), r, 1'($urandom));
        settle();
        send_sample(rand_sample(), LEN_W'(65535));
        for (int i = 0; i < 5; i++)
            send_sample(rand_sample(), LEN_W'($urandom));

        settle();
        $display("run covered %0d samples, %0d results and %0d register writes",
                 board.samples_seen, board.results_seen, board.writes_seen);
        $display("step and ratio from minimum to maximum, pcm16 on and off, %0d mismatches",
                 board.errors);
        if (board.errors == 0)
            $display("linear_interp_resampler_pcm16_top_tb OK");
        else
            $display("linear_interp_resampler_pcm16_top_tb NOT OK");
        $finish;
    end

endmodule

>>> linear_interp_resampler_pcm16_top.f
src/lirs_pkg.sv
src/lirs_if.sv
src/lirs_ctrl.sv
src/lirs_datapath.sv
src/linear_interp_resampler_pcm16_top.sv
bench/linear_interp_resampler_pcm16_top_tb.sv
